>>> design/bcl_pkg.sv
// Shared types and constants for the button code lock.
package bcl_pkg;

	// Lock modes as shown on the result stream
	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_UNLOCKED = 2'd1,
		MODE_BLOCKED  = 2'd2
	} mode_t;

	// Press classes
	typedef enum logic [1:0] {
		PRESS_NONE  = 2'd0,
		PRESS_SHORT = 2'd1,
		PRESS_LONG  = 2'd2
	} press_t;

	// Configuration port geometry and register indexes
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] CFG_SECRET        = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE      = 4'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS    = 4'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_ENTRY_TIMEOUT = 4'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK         = 4'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_GREEN_ON      = 4'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLINK         = 4'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WRONG     = 4'd7;

	// Fixed counter widths
	localparam int LED_W   = 16;
	localparam int BLOCK_W = 17;
	localparam int PHASE_W = 10;

	localparam logic [LED_W-1:0]   LONG_BLINK_TICKS   = 16'd1000;
	localparam logic [PHASE_W-1:0] BLOCK_PERIOD_LAST  = 10'd999;
	localparam logic [PHASE_W-1:0] BLOCK_ON_TICKS     = 10'd500;
	localparam logic [PHASE_W:0]   BLOCK_PERIOD_TICKS = 11'd1000;

	// Configuration register set; blink_mod is the blink length modulo the block period
	typedef struct packed {
		logic [7:0]         secret;
		logic [9:0]         debounce;
		logic [15:0]        long_press;
		logic [15:0]        entry_timeout;
		logic [15:0]        block_len;
		logic [15:0]        green_on;
		logic [15:0]        blink;
		logic [PHASE_W-1:0] blink_mod;
		logic [3:0]         max_wrong;
	} cfg_t;

	// One result item, first field in the highest bits
	typedef struct packed {
		press_t     press_seen;
		logic [2:0] entry_position;
		mode_t      lock_mode;
		logic       yellow_led;
		logic       red_led;
		logic       green_led;
	} res_t;

	localparam int RES_W   = $bits(res_t);
	localparam int TDATA_W = 16;

endpackage

>>> design/button_code_lock_with_lockout_core.sv
// Button code lock with strike lockout: input register, tick logic and result register.
//
// Each input transaction is one 1 ms tick carrying the raw button level; each tick
// yields exactly one result transaction with the LED drives, lock mode, matched
// position and the press classed on that tick. An item passes the input register, then
// the result register, and one item is taken every cycle unless the output stalls: the
// whole tick update is a single pass of counter compares between the two registers.
// While a result waits, one more item can still enter the input register; with both
// registers full the input stalls until the result is taken. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata by the user, only while no tick is in flight; the
// block does not enforce this. Indexes 8 to 15 are ignored.
module button_code_lock_with_lockout_core #(
	parameter int TIMER_BITS = 16,
	parameter int CODE_LEN   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [0] button_pressed
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] green_led, [1] red_led, [2] yellow_led, [4:3] lock_mode,
	// [7:5] entry_position, [9:8] press_seen
	output logic [bcl_pkg::TDATA_W-1:0]        m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [bcl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bcl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	bcl_pkg::cfg_t   cfg;
	bcl_pkg::press_t seen;
	bcl_pkg::res_t   res;

	logic            valid_s1;
	logic            button_s1;
	logic            res_valid_s2;
	bcl_pkg::res_t   res_s2;
	logic            advance;
	logic            tick;

	// Move on when the result register is empty or being drained
	assign advance       = !res_valid_s2 || m_axis_tready;
	assign tick          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	bcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bcl_debounce #(
		.TIMER_BITS (TIMER_BITS)
	) u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.raw            (button_s1),
		.debounce_ticks (cfg.debounce),
		.long_ticks     (cfg.long_press),
		.seen           (seen)
	);

	bcl_ctrl #(
		.TIMER_BITS (TIMER_BITS),
		.CODE_LEN   (CODE_LEN)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.seen   (seen),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			button_s1 <= s_axis_tdata[0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tdata  = {{(bcl_pkg::TDATA_W - bcl_pkg::RES_W){1'b0}}, res_s2};

endmodule

>>> design/bcl_cfg.sv
// Configuration register file for the button code lock.
module bcl_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bcl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bcl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output bcl_pkg::cfg_t                      cfg
);

	bcl_pkg::cfg_t cfg_q;

	logic [12:0] eighths;
	logic [26:0] recip_prod;
	logic [6:0]  thousands;
	logic [13:0] rem125;
	logic [bcl_pkg::PHASE_W-1:0] wdata_mod;

	// Reduce the written blink length modulo 1000: split off the low three bits,
	// then take the rest modulo 125 through a reciprocal multiply
	always_comb begin
		eighths    = cfg_wdata[15:3];
		recip_prod = 27'(eighths) * 27'd8389;
		thousands  = recip_prod[26:20];
		rem125     = 14'(eighths) - 14'(thousands) * 14'd125;
		wdata_mod  = {rem125[6:0], cfg_wdata[2:0]};
	end

	// Hold the registers; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.secret        <= 8'd154;
			cfg_q.debounce      <= 10'd20;
			cfg_q.long_press    <= 16'd500;
			cfg_q.entry_timeout <= 16'd5000;
			cfg_q.block_len     <= 16'd5000;
			cfg_q.green_on      <= 16'd2000;
			cfg_q.blink         <= 16'd100;
			cfg_q.blink_mod     <= 10'd100;
			cfg_q.max_wrong     <= 4'd3;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bcl_pkg::CFG_SECRET:        cfg_q.secret        <= cfg_wdata[7:0];
				bcl_pkg::CFG_DEBOUNCE:      cfg_q.debounce      <= cfg_wdata[9:0];
				bcl_pkg::CFG_LONG_PRESS:    cfg_q.long_press    <= cfg_wdata;
				bcl_pkg::CFG_ENTRY_TIMEOUT: cfg_q.entry_timeout <= cfg_wdata;
				bcl_pkg::CFG_BLOCK:         cfg_q.block_len     <= cfg_wdata;
				bcl_pkg::CFG_GREEN_ON:      cfg_q.green_on      <= cfg_wdata;
				bcl_pkg::CFG_BLINK: begin
					cfg_q.blink     <= cfg_wdata;
					cfg_q.blink_mod <= wdata_mod;
				end
				bcl_pkg::CFG_MAX_WRONG:     cfg_q.max_wrong     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/bcl_debounce.sv
// Button debouncer and press classifier, one update per tick.
module bcl_debounce #(
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                raw,
	input  logic [9:0]          debounce_ticks,
	input  logic [15:0]         long_ticks,
	output bcl_pkg::press_t     seen
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic                  raw_last_q;
	logic                  stable_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic [TIMER_BITS-1:0] press_len_q;

	logic                  raw_last_n;
	logic                  stable_n;
	logic [TIMER_BITS-1:0] elapsed_n;
	logic [TIMER_BITS-1:0] press_len_n;
	bcl_pkg::press_t       seen_n;

	// Advance the saturating counters, then follow the raw level
	always_comb begin
		raw_last_n  = raw_last_q;
		stable_n    = stable_q;
		elapsed_n   = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
		press_len_n = (&press_len_q) ? press_len_q : press_len_q + 1'b1;
		seen_n      = bcl_pkg::PRESS_NONE;
		if (raw != raw_last_q) begin
			raw_last_n = raw;
			elapsed_n  = '0;
		end else if (CMP_W'(elapsed_n) >= CMP_W'(debounce_ticks) && raw != stable_q) begin
			stable_n = raw;
			if (raw) begin
				press_len_n = '0;
			end else if (CMP_W'(press_len_n) >= CMP_W'(long_ticks)) begin
				seen_n = bcl_pkg::PRESS_LONG;
			end else if (CMP_W'(press_len_n) >= CMP_W'(debounce_ticks)) begin
				seen_n = bcl_pkg::PRESS_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q  <= 1'b0;
			stable_q    <= 1'b0;
			elapsed_q   <= '0;
			press_len_q <= '0;
		end else if (tick) begin
			raw_last_q  <= raw_last_n;
			stable_q    <= stable_n;
			elapsed_q   <= elapsed_n;
			press_len_q <= press_len_n;
		end
	end

	assign seen = seen_n;

endmodule

>>> design/bcl_ctrl.sv
// Lock sequencer: code matching, strikes, block phase and LED timers.
module bcl_ctrl #(
	parameter int TIMER_BITS = 16,
	parameter int CODE_LEN   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick,
	input  bcl_pkg::press_t seen,
	input  bcl_pkg::cfg_t   cfg,
	output bcl_pkg::res_t   res
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int LW    = bcl_pkg::LED_W;
	localparam int BW    = bcl_pkg::BLOCK_W;
	localparam int PW    = bcl_pkg::PHASE_W;

	bcl_pkg::mode_t        mode_q, mode_n;
	logic [2:0]            pos_q, pos_n;
	logic [3:0]            strikes_q, strikes_n;
	bcl_pkg::press_t       pending_q, pending_n;
	logic [TIMER_BITS-1:0] idle_q, idle_n;
	logic [LW-1:0]         green_q, green_n;
	logic [LW-1:0]         red_q, red_n;
	logic [LW-1:0]         yellow_q, yellow_n;
	logic [BW-1:0]         blk_q, blk_n;
	logic [PW-1:0]         phase_q, phase_n;

	logic                  red_drive;
	logic [PW:0]           phase_diff;
	logic [PW:0]           phase_adj;
	logic [BW-1:0]         block_stop;
	logic [LW-1:0]         blink_load;
	logic [LW-1:0]         green_load;
	logic [3:0]            pos_inc;
	logic                  sym_long;

	assign blink_load = (cfg.blink == '0) ? LW'(1) : cfg.blink;
	assign green_load = (cfg.green_on == '0) ? LW'(1) : cfg.green_on;
	assign block_stop = BW'(cfg.blink) + BW'(cfg.block_len);

	// Next state for one tick, in the order debounce, timers, block, timeout, symbol
	always_comb begin
		mode_n     = mode_q;
		pos_n      = pos_q;
		strikes_n  = strikes_q;
		pending_n  = (seen != bcl_pkg::PRESS_NONE) ? seen : pending_q;
		idle_n     = (&idle_q) ? idle_q : idle_q + 1'b1;
		green_n    = green_q;
		red_n      = (red_q != '0) ? red_q - 1'b1 : red_q;
		yellow_n   = (yellow_q != '0) ? yellow_q - 1'b1 : yellow_q;
		blk_n      = blk_q;
		phase_n    = phase_q;
		red_drive  = 1'b0;
		phase_diff = '0;
		phase_adj  = '0;
		pos_inc    = '0;
		sym_long   = 1'b0;

		// Green expiry ends the unlocked period
		if (green_q != '0) begin
			green_n = green_q - 1'b1;
			if (green_n == '0 && mode_q == bcl_pkg::MODE_UNLOCKED) begin
				mode_n = bcl_pkg::MODE_IDLE;
			end
		end

		// Block phase: strike blink delay, then 500 on / 500 off
		if (mode_n == bcl_pkg::MODE_BLOCKED) begin
			blk_n   = blk_q + 1'b1;
			phase_n = (phase_q == bcl_pkg::BLOCK_PERIOD_LAST) ? '0 : phase_q + 1'b1;
			if (blk_n >= block_stop) begin
				mode_n = bcl_pkg::MODE_IDLE;
				red_n  = '0;
			end else if (blk_n >= BW'(cfg.blink)) begin
				phase_diff = {1'b0, phase_n} - {1'b0, cfg.blink_mod};
				phase_adj  = phase_diff[PW] ? phase_diff + bcl_pkg::BLOCK_PERIOD_TICKS
				                            : phase_diff;
				red_drive  = (phase_adj[PW-1:0] < bcl_pkg::BLOCK_ON_TICKS);
			end
		end

		// Abandon a stale partial entry
		if (pos_q != '0 && CMP_W'(idle_n) >= CMP_W'(cfg.entry_timeout)) begin
			yellow_n = bcl_pkg::LONG_BLINK_TICKS;
			pos_n    = '0;
		end

		// Take a waiting press once the lock is idle
		if (pending_n != bcl_pkg::PRESS_NONE && mode_n == bcl_pkg::MODE_IDLE) begin
			sym_long = (pending_n == bcl_pkg::PRESS_LONG);
			if (sym_long == cfg.secret[pos_n]) begin
				yellow_n = blink_load;
				pos_inc  = {1'b0, pos_n} + 4'd1;
				pos_n    = pos_inc[2:0];
				if (pos_inc == 4'(CODE_LEN) || pos_inc == 4'd8) begin
					green_n   = green_load;
					mode_n    = bcl_pkg::MODE_UNLOCKED;
					pos_n     = '0;
					strikes_n = '0;
				end
			end else begin
				red_n     = blink_load;
				pos_n     = '0;
				strikes_n = strikes_q + 1'b1;
				if (strikes_n >= cfg.max_wrong) begin
					mode_n    = bcl_pkg::MODE_BLOCKED;
					blk_n     = '0;
					phase_n   = '0;
					strikes_n = '0;
				end
			end
			idle_n    = '0;
			pending_n = bcl_pkg::PRESS_NONE;
		end
	end

	// Result fields from the updated state
	always_comb begin
		res.green_led      = (green_n != '0);
		res.red_led        = (red_n != '0) || red_drive;
		res.yellow_led     = (yellow_n != '0);
		res.lock_mode      = mode_n;
		res.entry_position = pos_n;
		res.press_seen     = seen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= bcl_pkg::MODE_IDLE;
			pos_q     <= '0;
			strikes_q <= '0;
			pending_q <= bcl_pkg::PRESS_NONE;
			idle_q    <= '0;
			green_q   <= '0;
			red_q     <= '0;
			yellow_q  <= '0;
			blk_q     <= '0;
			phase_q   <= '0;
		end else if (tick) begin
			mode_q    <= mode_n;
			pos_q     <= pos_n;
			strikes_q <= strikes_n;
			pending_q <= pending_n;
			idle_q    <= idle_n;
			green_q   <= green_n;
			red_q     <= red_n;
			yellow_q  <= yellow_n;
			blk_q     <= blk_n;
			phase_q   <= phase_n;
		end
	end

endmodule

>>> design/bcl_checker.sv
// Port-level checks for the button code lock, bound to the top level.
module bcl_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tready,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bcl_pkg::TDATA_W-1:0]    m_axis_tdata
);

	bcl_pkg::res_t res;

	assign res = bcl_pkg::res_t'(m_axis_tdata[bcl_pkg::RES_W-1:0]);

	// A stalled result transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// With the result side empty, the input side always takes a transaction
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// Unlocked only while green is lit
	a_unlock_green: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.lock_mode == bcl_pkg::MODE_UNLOCKED |-> res.green_led)
		else $error("unlocked without green");

	// No partial entry survives into or during a block
	a_block_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.lock_mode == bcl_pkg::MODE_BLOCKED |-> res.entry_position == 3'd0)
		else $error("entry position kept while blocked");

endmodule

bind button_code_lock_with_lockout_core bcl_checker u_bcl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
